### rtl/aasp_pkg.sv
// Shared types, constants and helpers for the asset amount string parser.
package aasp_pkg;

  localparam int NAME_CHARS = 7;
  localparam int NAME_W     = NAME_CHARS * 8;
  localparam int NLEN_W     = $clog2(NAME_CHARS + 1);
  localparam int MAG_W      = 64;
  localparam int ACC_W      = MAG_W + 4;
  localparam int PREC_W     = 8;
  localparam int CHAR_W     = 8;

  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam logic [PREC_W-1:0] MAX_PREC_RST = 8'd18;

  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UPA   = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UPZ   = 8'h5A;

  localparam logic [ACC_W-1:0] LIMIT_POS = {{(ACC_W-MAG_W+1){1'b0}}, {(MAG_W-1){1'b1}}};
  localparam logic [ACC_W-1:0] LIMIT_NEG = LIMIT_POS + 1'b1;

  typedef enum logic [2:0] {
    CLS_SPACE,
    CLS_DOT,
    CLS_PLUS,
    CLS_MINUS,
    CLS_DIGIT,
    CLS_OTHER
  } cls_e;

  typedef enum logic [1:0] {
    ERR_NONE,
    ERR_BAD,
    ERR_OVER,
    ERR_UNDER
  } amt_err_e;

  typedef enum logic [2:0] {
    ST_OK,
    ST_BAD_SPACES,
    ST_PREC_LARGE,
    ST_BAD_NAME,
    ST_BAD_NUMBER,
    ST_OVERFLOW,
    ST_UNDERFLOW
  } status_e;

  typedef struct packed {
    cls_e              cls;
    logic [3:0]        digit;
    logic [CHAR_W-1:0] ch;
    logic              last;
  } item_t;

  typedef struct packed {
    logic              in_name;
    logic              extra;
    logic              dot;
    logic              amt_seen;
    logic              dig_seen;
    logic              neg;
    logic [MAG_W-1:0]  mag;
    amt_err_e          err;
    logic [PREC_W-1:0] prec;
    logic [NAME_W-1:0] name;
    logic [NLEN_W-1:0] nlen;
  } pstate_t;

  function automatic logic name_valid(logic [NAME_W-1:0] code);
    logic       ok;
    logic       ended;
    logic [7:0] b;
    ok    = 1'b1;
    ended = 1'b0;
    for (int i = 0; i < NAME_CHARS; i++) begin
      b = code[i*8 +: 8];
      if (ended) begin
        if (b != 8'h00) ok = 1'b0;
      end else if (b == 8'h00) begin
        if (i == 0) ok = 1'b0;
        ended = 1'b1;
      end else if (b < CH_UPA || b > CH_UPZ) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

endpackage

### rtl/aasp_front.sv
// Input side: accepts characters, classifies them and pushes them into the queue.
module aasp_front (
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [7:0]                 ch_i,
  input  logic                       last_i,
  input  logic                       q_full_i,
  output logic                       q_push_o,
  output aasp_pkg::item_t            q_item_o
);
  import aasp_pkg::*;

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  always_comb begin
    q_item_o.ch    = ch_i;
    q_item_o.last  = last_i;
    q_item_o.digit = ch_i[3:0];
    if (ch_i == CH_SPACE) begin
      q_item_o.cls = CLS_SPACE;
    end else if (ch_i == CH_DOT) begin
      q_item_o.cls = CLS_DOT;
    end else if (ch_i == CH_PLUS) begin
      q_item_o.cls = CLS_PLUS;
    end else if (ch_i == CH_MINUS) begin
      q_item_o.cls = CLS_MINUS;
    end else if (ch_i inside {[CH_ZERO:CH_NINE]}) begin
      q_item_o.cls = CLS_DIGIT;
    end else begin
      q_item_o.cls = CLS_OTHER;
    end
  end

endmodule

### rtl/aasp_fifo.sv
// Short queue of classified characters between the front and the parser.
module aasp_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  aasp_pkg::item_t  item_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output aasp_pkg::item_t  item_o
);
  import aasp_pkg::*;

  item_t                 mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wptr_q, wptr_d;
  logic [FIFO_PTR_W-1:0] rptr_q, rptr_d;
  logic [FIFO_CNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == FIFO_CNT_W'(FIFO_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d = push_i ? wptr_q + 1'b1 : wptr_q;
    rptr_d = pop_i  ? rptr_q + 1'b1 : rptr_q;
    cnt_d  = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= item_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FIFO_CNT_W'(FIFO_DEPTH)) else $error("queue count beyond depth");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o) else $error("pop from empty queue");

endmodule

### rtl/aasp_parse.sv
// Back end: per-character parse state update and end-of-string snapshot.
module aasp_parse (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              item_valid_i,
  input  aasp_pkg::item_t   item_i,
  output logic              pop_o,
  output logic              fin_valid_o,
  output aasp_pkg::pstate_t fin_o,
  input  logic              fin_take_i
);
  import aasp_pkg::*;

  pstate_t          st_q, st_d, st_n;
  pstate_t          fin_q;
  logic             fin_valid_q, fin_valid_d;
  logic             fin_ready;
  logic             take;
  logic [ACC_W-1:0] acc_ext;
  logic [ACC_W-1:0] acc;
  logic [ACC_W-1:0] limit;
  logic             ovf;

  assign fin_ready   = !fin_valid_q || fin_take_i;
  assign take        = item_valid_i && (!item_i.last || fin_ready);
  assign pop_o       = take;
  assign fin_valid_o = fin_valid_q;
  assign fin_o       = fin_q;

  assign acc_ext = {{(ACC_W-MAG_W){1'b0}}, st_q.mag};
  assign acc     = (acc_ext << 3) + (acc_ext << 1) + {{(ACC_W-4){1'b0}}, item_i.digit};
  assign limit   = st_q.neg ? LIMIT_NEG : LIMIT_POS;
  assign ovf     = (acc > limit);

  always_comb begin
    st_n = st_q;
    if (item_i.cls == CLS_SPACE) begin
      if (st_q.in_name) st_n.extra = 1'b1;
      else              st_n.in_name = 1'b1;
    end else if (st_q.in_name) begin
      if (st_q.nlen < NLEN_W'(NAME_CHARS)) begin
        st_n.name[{st_q.nlen, 3'b000} +: 8] = item_i.ch;
        st_n.nlen = st_q.nlen + 1'b1;
      end
    end else if (item_i.cls == CLS_DOT && !st_q.dot) begin
      st_n.dot = 1'b1;
    end else begin
      if (st_q.dot) st_n.prec = st_q.prec + 1'b1;
      st_n.amt_seen = 1'b1;
      if (!st_q.amt_seen && (item_i.cls == CLS_PLUS || item_i.cls == CLS_MINUS)) begin
        st_n.neg = (item_i.cls == CLS_MINUS);
      end else if (st_q.err == ERR_NONE) begin
        if (item_i.cls != CLS_DIGIT) begin
          st_n.err = ERR_BAD;
        end else if (ovf) begin
          st_n.err = st_q.neg ? ERR_UNDER : ERR_OVER;
        end else begin
          st_n.mag      = acc[MAG_W-1:0];
          st_n.dig_seen = 1'b1;
        end
      end
    end
  end

  always_comb begin
    st_d        = st_q;
    fin_valid_d = fin_take_i ? 1'b0 : fin_valid_q;
    if (take) begin
      if (item_i.last) begin
        st_d        = '0;
        fin_valid_d = 1'b1;
      end else begin
        st_d = st_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= '0;
      fin_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      fin_valid_q <= fin_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && item_i.last) begin
      fin_q <= st_n;
    end
  end

  a_nlen_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.nlen <= NLEN_W'(NAME_CHARS)) else $error("name length beyond limit");

  a_fin_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_valid_q && !fin_take_i |=> fin_valid_q && $stable(fin_q))
    else $error("pending snapshot lost");

endmodule

### rtl/aasp_result.sv
// Result stage: status priority, sign apply and the output register.
module aasp_result (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              max_precision_we_i,
  input  logic [7:0]        max_precision_i,
  input  logic              fin_valid_i,
  input  aasp_pkg::pstate_t fin_i,
  output logic              fin_take_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic signed [63:0] units_o,
  output logic [7:0]        precision_o,
  output logic [55:0]       symbol_name_o,
  output logic [2:0]        status_o
);
  import aasp_pkg::*;

  logic [PREC_W-1:0] max_prec_q;
  logic              out_valid_q;
  logic [MAG_W-1:0]  units_q, units_d;
  logic [PREC_W-1:0] prec_q, prec_d;
  logic [NAME_W-1:0] name_q, name_d;
  status_e           status_q, status_d;

  assign fin_take_o    = fin_valid_i && (!out_valid_q || !out_stall_i);
  assign out_valid_o   = out_valid_q;
  assign units_o       = units_q;
  assign precision_o   = prec_q;
  assign symbol_name_o = name_q;
  assign status_o      = status_q;

  always_comb begin
    if (!fin_i.in_name || fin_i.extra) begin
      status_d = ST_BAD_SPACES;
    end else if (fin_i.prec > max_prec_q) begin
      status_d = ST_PREC_LARGE;
    end else if ((fin_i.name != '0 || fin_i.prec != '0) && !name_valid(fin_i.name)) begin
      status_d = ST_BAD_NAME;
    end else if (fin_i.err == ERR_BAD || (fin_i.err == ERR_NONE && !fin_i.dig_seen)) begin
      status_d = ST_BAD_NUMBER;
    end else if (fin_i.err == ERR_OVER) begin
      status_d = ST_OVERFLOW;
    end else if (fin_i.err == ERR_UNDER) begin
      status_d = ST_UNDERFLOW;
    end else begin
      status_d = ST_OK;
    end
    if (status_d == ST_OK) begin
      units_d = fin_i.neg ? (~fin_i.mag + 1'b1) : fin_i.mag;
      prec_d  = fin_i.prec;
      name_d  = fin_i.name;
    end else begin
      units_d = '0;
      prec_d  = '0;
      name_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_prec_q  <= MAX_PREC_RST;
      out_valid_q <= 1'b0;
    end else begin
      if (max_precision_we_i) max_prec_q <= max_precision_i;
      if (fin_take_o) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_take_o) begin
      units_q  <= units_d;
      prec_q   <= prec_d;
      name_q   <= name_d;
      status_q <= status_d;
    end
  end

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && status_q != ST_OK |-> units_q == '0 && prec_q == '0 && name_q == '0)
    else $error("error result carries nonzero fields");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_take_o |-> fin_valid_i) else $error("result taken without snapshot");

endmodule

### rtl/asset_amount_string_parser.sv
// Top level of the asset amount string parser.
// Takes one character of an "amount SYMBOL" string per cycle (ch_i, last_i) and gives
// one result per string, through the snapshot and output registers. A character is
// accepted every cycle while the output keeps draining; the rate is one character per
// cycle, set by the parser stage, whose per-character update is one multiply-by-ten add
// and compare on the 64-bit magnitude. A two-entry queue between the classifying front
// and the parser, a snapshot register and the output register let either side stall on
// its own. max_precision (reset 18) is written through max_precision_we_i / max_precision_i;
// the user must write it only while the block is idle; the block does not enforce this.
module asset_amount_string_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         ch_i,
  input  logic               last_i,
  input  logic               max_precision_we_i,
  input  logic [7:0]         max_precision_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [63:0] units_o,
  output logic [7:0]         precision_o,
  output logic [55:0]        symbol_name_o,
  output logic [2:0]         status_o
);
  import aasp_pkg::*;

  item_t   push_item;
  item_t   pop_item;
  logic    q_full;
  logic    q_push;
  logic    q_pop;
  logic    q_valid;
  pstate_t fin;
  logic    fin_valid;
  logic    fin_take;

  aasp_front u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .ch_i       (ch_i),
    .last_i     (last_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_item_o   (push_item)
  );

  aasp_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (push_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (pop_item)
  );

  aasp_parse u_parse (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (q_valid),
    .item_i       (pop_item),
    .pop_o        (q_pop),
    .fin_valid_o  (fin_valid),
    .fin_o        (fin),
    .fin_take_i   (fin_take)
  );

  aasp_result u_result (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .max_precision_we_i (max_precision_we_i),
    .max_precision_i    (max_precision_i),
    .fin_valid_i        (fin_valid),
    .fin_i              (fin),
    .fin_take_o         (fin_take),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .units_o            (units_o),
    .precision_o        (precision_o),
    .symbol_name_o      (symbol_name_o),
    .status_o           (status_o)
  );

endmodule
